// ===== src/kns_pkg.sv =====
`default_nettype none

package kns_pkg;

  // Default and upper bound of the key length the window can hold.
  localparam int unsigned KEY_MAX_DEF = 8;

  // Fixed field widths.
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned KLEN_W    = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TOTAL_W   = 31;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned CFG_IDX_W = 1;

  // Saturation limit of numbers and of the total.
  localparam logic [TOTAL_W-1:0] LIMIT = {TOTAL_W{1'b1}};

  // ASCII codes of the characters zero and nine.
  localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'd57;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

  // Per-word control handed from the window to the accumulator.
  typedef struct packed {
    logic               accept;
    logic               last;
    logic               match;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
  } scan_ctrl_t;

  // Result handed back to the output register.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               saturated;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== src/kns_cell.sv =====
`default_nettype none

module kns_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       shift_i,
  input  wire logic                       clear_i,
  input  wire logic [kns_pkg::BYTE_W-1:0] byte_i,
  input  wire logic                       valid_i,
  input  wire logic [kns_pkg::BYTE_W-1:0] key_char_i,
  input  wire logic                       enable_i,
  output logic      [kns_pkg::BYTE_W-1:0] byte_o,
  output logic                            valid_o,
  output logic                            hit_o
);
  import kns_pkg::*;

  logic [BYTE_W-1:0] byte_q;
  logic              valid_q, valid_d;

  // The compare looks at the byte arriving in this cycle, i.e. the window
  // as it stands once the new character has been shifted in.
  assign hit_o = !enable_i || (valid_i && (byte_i == key_char_i));

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (shift_i) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== src/kns_accum.sv =====
`default_nettype none

module kns_accum (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kns_pkg::scan_ctrl_t ctrl_i,
  output kns_pkg::scan_res_t       res_o
);
  import kns_pkg::*;

  logic [TOTAL_W-1:0] value_q, value_d;
  logic               active_q, active_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               limit_q, limit_d;

  logic               extend;
  logic [TOTAL_W+3:0] prod;
  logic               prod_sat;
  logic [TOTAL_W-1:0] ext_value;
  logic               commit;
  logic [TOTAL_W:0]   sum;
  logic               sum_sat;
  logic [TOTAL_W-1:0] total_new;
  logic               limit_new;

  always_comb begin
    extend    = active_q && ctrl_i.is_digit;
    // Times ten as two shifted copies, then the new digit.
    prod      = ({4'b0000, value_q} << 3) + ({4'b0000, value_q} << 1)
                + {{(TOTAL_W){1'b0}}, ctrl_i.digit};
    prod_sat  = prod > {4'b0000, LIMIT};
    ext_value = extend ? (prod_sat ? LIMIT : prod[TOTAL_W-1:0]) : value_q;

    // At most one number reaches the total per word: a non-digit, a new
    // match or the end of the text closes the pending one.
    commit    = active_q && (!ctrl_i.is_digit || ctrl_i.match || ctrl_i.last);
    sum       = {1'b0, total_q} + {1'b0, ext_value};
    sum_sat   = sum > {1'b0, LIMIT};
    total_new = commit ? (sum_sat ? LIMIT : sum[TOTAL_W-1:0]) : total_q;
    limit_new = limit_q || (extend && prod_sat) || (commit && sum_sat);

    value_d  = value_q;
    active_d = active_q;
    total_d  = total_q;
    limit_d  = limit_q;
    if (ctrl_i.accept) begin
      if (ctrl_i.last) begin
        value_d  = '0;
        active_d = 1'b0;
        total_d  = '0;
        limit_d  = 1'b0;
      end else begin
        total_d  = total_new;
        limit_d  = limit_new;
        active_d = ctrl_i.match || extend;
        value_d  = (!ctrl_i.match && extend) ? ext_value : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q  <= '0;
      active_q <= 1'b0;
      total_q  <= '0;
      limit_q  <= 1'b0;
    end else begin
      value_q  <= value_d;
      active_q <= active_d;
      total_q  <= total_d;
      limit_q  <= limit_d;
    end
  end

  assign res_o.total     = total_new;
  assign res_o.saturated = limit_new;

endmodule

`default_nettype wire

// ===== src/keyed_number_sum_scanner.sv =====
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+--------------------------
// in       | in_valid_i / in_stall_o     | text_byte_i, last_i
// out      | out_valid_o / out_stall_i   | total_o, saturated_o
// cfg      | cfg_we_i (no wait)          | cfg_index_i, cfg_data_i
//
// One word is accepted every cycle unless a last word is stalled; the key
// compare and the number update finish in the cycle of acceptance.
// The result of a word marked last appears in the output register on the
// next cycle and waits there until taken.
// While a result waits under stall, words without last are still taken;
// only a further last word is held back.
// Reset clears the window, the number, the total and the key registers
// (key length one, key bytes zero).
`default_nettype none

module keyed_number_sum_scanner #(
  parameter int unsigned KeyMax = kns_pkg::KEY_MAX_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [kns_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [kns_pkg::KEY_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [kns_pkg::BYTE_W-1:0]    text_byte_i,
  input  wire logic                          last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [kns_pkg::TOTAL_W-1:0]   total_o,
  output logic                               saturated_o
);
  import kns_pkg::*;

  // Configuration registers.
  logic [KEY_W-1:0]  key_q;
  logic [KLEN_W-1:0] klen_q;
  logic [KLEN_W-1:0] len_used;

  // Window chain.
  logic [BYTE_W-1:0] chain_byte [KeyMax+1];
  logic              chain_valid[KeyMax+1];
  logic [KeyMax-1:0] hits;

  logic       accept;
  logic       is_digit;
  scan_ctrl_t ctrl;
  scan_res_t  res;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [TOTAL_W-1:0] out_total_q;
  logic               out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      klen_q <= KLEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_KEY_BYTES:  key_q  <= cfg_data_i;
        REG_KEY_LENGTH: klen_q <= cfg_data_i[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero length behaves as one, anything beyond the window as its size.
  always_comb begin
    if (klen_q == '0) begin
      len_used = KLEN_W'(1);
    end else if (klen_q > KLEN_W'(KeyMax)) begin
      len_used = KLEN_W'(KeyMax);
    end else begin
      len_used = klen_q;
    end
  end

  // A last word may only enter when the output register is free to take
  // its result; other words always enter.
  assign in_stall_o = out_valid_q && out_stall_i && last_i;
  assign accept     = in_valid_i && !in_stall_o;

  // The newest character enters cell zero; cell i is fed the character that
  // arrived i words ago and compares it with key character len-1-i. A cell
  // beyond the key length always agrees. The valid bits running along the
  // chain tell whether enough characters have been seen for a full key.
  assign chain_byte[0]  = text_byte_i;
  assign chain_valid[0] = 1'b1;

  for (genvar i = 0; i < KeyMax; i++) begin : g_cell
    logic [2:0]        key_pos;
    logic              cell_en;
    logic [BYTE_W-1:0] key_char;

    assign cell_en  = KLEN_W'(i) < len_used;
    assign key_pos  = 3'(len_used - KLEN_W'(1) - KLEN_W'(i));
    assign key_char = key_q[BYTE_W*key_pos +: BYTE_W];

    kns_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .clear_i    (accept && last_i),
      .byte_i     (chain_byte[i]),
      .valid_i    (chain_valid[i]),
      .key_char_i (key_char),
      .enable_i   (cell_en),
      .byte_o     (chain_byte[i+1]),
      .valid_o    (chain_valid[i+1]),
      .hit_o      (hits[i])
    );
  end

  assign is_digit = text_byte_i inside {[DIGIT_ZERO:DIGIT_NINE]};

  always_comb begin
    ctrl.accept   = accept;
    ctrl.last     = last_i;
    ctrl.match    = &hits;
    ctrl.is_digit = is_digit;
    ctrl.digit    = DIGIT_W'(text_byte_i - DIGIT_ZERO);
  end

  // Pending number, running total and saturation flag.
  kns_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && last_i) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      out_total_q <= res.total;
      out_sat_q   <= res.saturated;
    end
  end

  assign out_valid_o = out_valid_q;
  assign total_o     = out_total_q;
  assign saturated_o = out_sat_q;

endmodule

`default_nettype wire
